// ===== rtl/core/lci_pkg.sv =====
package lci_pkg;

  localparam int CW     = 32;
  localparam int RADW   = 31;
  localparam int DFW    = 33;
  localparam int QW     = 68;
  localparam int SQ_IN  = 132;
  localparam int NUMW   = 102;
  localparam int DENW   = 67;
  localparam int QB     = 36;
  localparam int LAT    = 120;

  localparam logic [QB-1:0] QLIM   = 36'h4_0000_0000;
  localparam logic [CW-1:0] PT_MAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] PT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [CW-1:0]  sx;
    logic [CW-1:0]  sy;
    logic [DFW-1:0] dx;
    logic [DFW-1:0] dy;
  } side_t;

endpackage

// ===== rtl/core/lci_dly.sv =====
module lci_dly #(
  parameter int W = lci_pkg::CW,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

// ===== rtl/core/lci_mul.sv =====
module lci_mul #(
  parameter int WA = lci_pkg::DFW,
  parameter int WB = lci_pkg::DFW
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int LA = WA / 2;
  localparam int HA = WA - LA;
  localparam int LB = WB / 2;
  localparam int HB = WB - LB;
  localparam int RW = WA + WB;

  logic [LA-1:0]           a_l;
  logic signed [HA-1:0]    a_h;
  logic [LB-1:0]           b_l;
  logic signed [HB-1:0]    b_h;

  logic [LA+LB-1:0]        pll_r, pll_nxt;
  logic signed [HA+HB-1:0] phh_r, phh_nxt;
  logic signed [HA+LB:0]   phl_r, phl_nxt;
  logic signed [LA+HB:0]   plh_r, plh_nxt;
  logic signed [RW-1:0]    xhl, xlh;
  logic signed [RW-1:0]    sa_r, sa_nxt, sb_r, sb_nxt;
  logic signed [RW-1:0]    p_r;

  assign a_l = a[LA-1:0];
  assign a_h = a[WA-1:LA];
  assign b_l = b[LB-1:0];
  assign b_h = b[WB-1:LB];

  // signed high limb, unsigned low limb
  always_comb begin
    pll_nxt = a_l * b_l;
    phh_nxt = a_h * b_h;
    phl_nxt = a_h * $signed({1'b0, b_l});
    plh_nxt = $signed({1'b0, a_l}) * b_h;
  end

  always_comb begin
    xhl    = {{(RW-HA-LB-1){phl_r[HA+LB]}}, phl_r};
    xlh    = {{(RW-LA-HB-1){plh_r[LA+HB]}}, plh_r};
    sa_nxt = {phh_r, pll_r};
    sb_nxt = (xhl <<< LA) + (xlh <<< LB);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= pll_nxt;
      phh_r <= phh_nxt;
      phl_r <= phl_nxt;
      plh_r <= plh_nxt;
      sa_r  <= sa_nxt;
      sb_r  <= sb_nxt;
      p_r   <= sa_r + sb_r;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/core/lci_sqrt.sv =====
module lci_sqrt #(
  parameter int IW = lci_pkg::SQ_IN
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   x,
  output logic [IW/2-1:0] root
);

  localparam int K  = IW / 2;
  localparam int RW = K + 3;

  logic [RW-1:0] rem_r  [K-1];
  logic [IW-1:0] x_r    [K-1];
  logic [K-1:0]  root_r [K];

  for (genvar i = 0; i < K; i++) begin : g_stage
    logic [RW-1:0] rem_p, t, trial;
    logic [K-1:0]  root_p;
    logic [IW-1:0] x_p;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign x_p    = x_r[i-1];
    end

    assign t     = {rem_p[RW-3:0], x_p[IW-1:IW-2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= {root_p[K-2:0], ge};
      end
    end

    if (i < K - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? (t - trial) : t;
          x_r[i]   <= {x_p[IW-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[K-1];

endmodule

// ===== rtl/core/lci_div.sv =====
module lci_div #(
  parameter int NW = lci_pkg::NUMW,
  parameter int DW = lci_pkg::DENW,
  parameter int QB = lci_pkg::QB
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] q,
  output logic          ovf
);

  logic [DW-1:0] rem0_r, den0_r;
  logic [QB-1:0] lo0_r;
  logic          ovf0_r;

  logic [DW-1:0] rem_r [QB-1];
  logic [DW-1:0] den_r [QB-1];
  logic [QB-1:0] lo_r  [QB-1];
  logic [QB-1:0] q_r   [QB];
  logic          ovf_r [QB];

  // quotient beyond QB bits is flagged, not computed
  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= DW'(num[NW-1:QB]);
      lo0_r  <= num[QB-1:0];
      den0_r <= den;
      ovf0_r <= (DW'(num[NW-1:QB]) >= den);
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DW-1:0] rem_p, den_p;
    logic [QB-1:0] lo_p, q_p;
    logic          ovf_p;
    logic [DW:0]   t, diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_p = rem0_r;
      assign den_p = den0_r;
      assign lo_p  = lo0_r;
      assign q_p   = '0;
      assign ovf_p = ovf0_r;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign den_p = den_r[i-1];
      assign lo_p  = lo_r[i-1];
      assign q_p   = q_r[i-1];
      assign ovf_p = ovf_r[i-1];
    end

    assign t    = {rem_p, lo_p[QB-1]};
    assign diff = t - {1'b0, den_p};
    assign ge   = (t >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]   <= {q_p[QB-2:0], ge};
        ovf_r[i] <= ovf_p;
      end
    end

    if (i < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
          den_r[i] <= den_p;
          lo_r[i]  <= {lo_p[QB-2:0], 1'b0};
        end
      end
    end
  end

  assign q   = q_r[QB-1];
  assign ovf = ovf_r[QB-1];

endmodule

// ===== rtl/core/line_circle_intersection_core.sv =====
// channel | dir | bits                      | contents
// in_*    | in  | tdata 224                 | request: segment, centre, radius
// out_*   | out | tdata 64, tuser 2         | intersection point, hit and clip flags
//
// Fully pipelined: one request per cycle while the output is not stalled.
// Latency is set by the 66-step square root and the two 37-step dividers.
// rst_n is synchronous, active low, and clears the valid bits only.
// The whole pipeline freezes while a result waits at the output and out_tready is low.
module line_circle_intersection_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,   // start_x, start_y, end_x, end_y, center_x, center_y,
                                   // circle_radius[222:192], pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // point_x, point_y
  output logic [1:0]   out_tuser   // hit, clipped
);

  import lci_pkg::*;

  localparam int PW  = 2 * DFW;
  localparam int RPW = 2 * CW;
  localparam int BBW = 2 * QW;
  localparam int SQW = SQ_IN / 2;
  localparam int NDW = QW + DFW;

  logic en;
  logic [LAT:0] vld_r;

  logic [CW-1:0]   sx0_r, sy0_r, ex0_r, ey0_r, cx0_r, cy0_r;
  logic [RADW-1:0] rad0_r, rad1_r;
  logic [CW-1:0]   sx1_r, sy1_r;
  logic signed [DFW-1:0] dx1_r, dy1_r, rx1_r, ry1_r;

  logic signed [PW-1:0]  dxx4, dyy4, rxdx4, rydy4, rxx4, ryy4;
  logic signed [RPW-1:0] rsq4;
  logic signed [QW-1:0]  a5_r, b5_r, rr5_r, rsq5_r;
  logic signed [QW-1:0]  a6_r, b6_r, c6_r;
  logic                  az6_r;
  logic signed [BBW-1:0] bb9, ac9, d10;
  logic [SQ_IN-1:0]      dsq10_r;
  logic                  dng10_r;

  logic [SQW-1:0]        s76;
  logic signed [QW-1:0]  b76;
  logic                  az76, dng76;
  side_t                 side1, side77;
  logic signed [QW-1:0]  n77_r;
  logic                  hit77_r;

  logic signed [NDW-1:0] px80, py80;
  logic [NDW-1:0]        mx81_r, my81_r;
  logic                  ngx81_r, ngy81_r;
  logic signed [QW-1:0]  a81;
  logic [NUMW-1:0]       numx82_r, numy82_r;
  logic [DENW-1:0]       den82_r;
  logic                  ngx82_r, ngy82_r;

  logic [QB-1:0]         qx119, qy119;
  logic                  ovx119, ovy119, ngx119, ngy119, hit119;
  logic [CW-1:0]         sx119, sy119;
  logic [CW:0]           resx, resy;

  logic [CW-1:0]         px_r, py_r;
  logic                  hit_r, clip_r;

  assign en         = ~out_tvalid | out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx0_r  <= in_tdata[31:0];
      sy0_r  <= in_tdata[63:32];
      ex0_r  <= in_tdata[95:64];
      ey0_r  <= in_tdata[127:96];
      cx0_r  <= in_tdata[159:128];
      cy0_r  <= in_tdata[191:160];
      rad0_r <= in_tdata[222:192];

      dx1_r  <= {ex0_r[CW-1], ex0_r} - {sx0_r[CW-1], sx0_r};
      dy1_r  <= {ey0_r[CW-1], ey0_r} - {sy0_r[CW-1], sy0_r};
      rx1_r  <= {sx0_r[CW-1], sx0_r} - {cx0_r[CW-1], cx0_r};
      ry1_r  <= {sy0_r[CW-1], sy0_r} - {cy0_r[CW-1], cy0_r};
      sx1_r  <= sx0_r;
      sy1_r  <= sy0_r;
      rad1_r <= rad0_r;
    end
  end

  lci_mul #(.WA(DFW), .WB(DFW)) u_mdxx (.clk, .en, .a(dx1_r), .b(dx1_r), .p(dxx4));
  lci_mul #(.WA(DFW), .WB(DFW)) u_mdyy (.clk, .en, .a(dy1_r), .b(dy1_r), .p(dyy4));
  lci_mul #(.WA(DFW), .WB(DFW)) u_mrdx (.clk, .en, .a(rx1_r), .b(dx1_r), .p(rxdx4));
  lci_mul #(.WA(DFW), .WB(DFW)) u_mrdy (.clk, .en, .a(ry1_r), .b(dy1_r), .p(rydy4));
  lci_mul #(.WA(DFW), .WB(DFW)) u_mrxx (.clk, .en, .a(rx1_r), .b(rx1_r), .p(rxx4));
  lci_mul #(.WA(DFW), .WB(DFW)) u_mryy (.clk, .en, .a(ry1_r), .b(ry1_r), .p(ryy4));
  lci_mul #(.WA(CW), .WB(CW)) u_mrad (
    .clk, .en, .a({1'b0, rad1_r}), .b({1'b0, rad1_r}), .p(rsq4)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      a5_r   <= {{(QW-PW){dxx4[PW-1]}}, dxx4} + {{(QW-PW){dyy4[PW-1]}}, dyy4};
      b5_r   <= {{(QW-PW){rxdx4[PW-1]}}, rxdx4} + {{(QW-PW){rydy4[PW-1]}}, rydy4};
      rr5_r  <= {{(QW-PW){rxx4[PW-1]}}, rxx4} + {{(QW-PW){ryy4[PW-1]}}, ryy4};
      rsq5_r <= {{(QW-RPW){rsq4[RPW-1]}}, rsq4};

      a6_r   <= a5_r;
      b6_r   <= b5_r;
      c6_r   <= rr5_r - rsq5_r;
      az6_r  <= (a5_r == '0);
    end
  end

  lci_mul #(.WA(QW), .WB(QW)) u_mbb (.clk, .en, .a(b6_r), .b(b6_r), .p(bb9));
  lci_mul #(.WA(QW), .WB(QW)) u_mac (.clk, .en, .a(a6_r), .b(c6_r), .p(ac9));

  assign d10 = bb9 - ac9;

  always_ff @(posedge clk) begin
    if (en) begin
      dsq10_r <= d10[SQ_IN-1:0];
      dng10_r <= d10[BBW-1];
    end
  end

  lci_sqrt #(.IW(SQ_IN)) u_sqrt (.clk, .en, .x(dsq10_r), .root(s76));

  assign side1 = {sx1_r, sy1_r, dx1_r, dy1_r};

  lci_dly #(.W($bits(side_t)), .N(76)) u_dside (.clk, .en, .d(side1), .q(side77));
  lci_dly #(.W(QW + 1), .N(70)) u_db (.clk, .en, .d({b6_r, az6_r}), .q({b76, az76}));
  lci_dly #(.W(1), .N(66)) u_ddng (.clk, .en, .d(dng10_r), .q(dng76));
  lci_dly #(.W(QW), .N(75)) u_da (.clk, .en, .d(a6_r), .q(a81));

  always_ff @(posedge clk) begin
    if (en) begin
      n77_r   <= -b76 - $signed({{(QW-SQW){1'b0}}, s76});
      hit77_r <= ~az76 & ~dng76;
    end
  end

  lci_mul #(.WA(QW), .WB(DFW)) u_mnx (
    .clk, .en, .a(n77_r), .b($signed(side77.dx)), .p(px80)
  );
  lci_mul #(.WA(QW), .WB(DFW)) u_mny (
    .clk, .en, .a(n77_r), .b($signed(side77.dy)), .p(py80)
  );

  lci_dly #(.W(2 * CW + 1), .N(42)) u_dpt (
    .clk, .en, .d({side77.sx, side77.sy, hit77_r}), .q({sx119, sy119, hit119})
  );

  // magnitude, then round half away from zero: (2|p| + A) / 2A
  always_ff @(posedge clk) begin
    if (en) begin
      ngx81_r  <= px80[NDW-1];
      ngy81_r  <= py80[NDW-1];
      mx81_r   <= px80[NDW-1] ? -px80 : px80;
      my81_r   <= py80[NDW-1] ? -py80 : py80;

      numx82_r <= {mx81_r, 1'b0} + NUMW'(a81[DENW-2:0]);
      numy82_r <= {my81_r, 1'b0} + NUMW'(a81[DENW-2:0]);
      den82_r  <= {a81[DENW-2:0], 1'b0};
      ngx82_r  <= ngx81_r;
      ngy82_r  <= ngy81_r;
    end
  end

  lci_div #(.NW(NUMW), .DW(DENW), .QB(QB)) u_divx (
    .clk, .en, .num(numx82_r), .den(den82_r), .q(qx119), .ovf(ovx119)
  );
  lci_div #(.NW(NUMW), .DW(DENW), .QB(QB)) u_divy (
    .clk, .en, .num(numy82_r), .den(den82_r), .q(qy119), .ovf(ovy119)
  );

  lci_dly #(.W(2), .N(37)) u_dng (
    .clk, .en, .d({ngx82_r, ngy82_r}), .q({ngx119, ngy119})
  );

  // {clip, value}
  function automatic logic [CW:0] axis_out(
    input logic [CW-1:0] st,
    input logic [QB-1:0] q,
    input logic          ovf,
    input logic          ng
  );
    logic signed [QB+2:0] sum;
    logic                 big;
    logic [CW:0]          r;
    big = ovf | (q > QLIM);
    sum = ng ? ({{(QB+3-CW){st[CW-1]}}, st} - {3'b000, q})
             : ({{(QB+3-CW){st[CW-1]}}, st} + {3'b000, q});
    if (big) begin
      r = {1'b1, ng ? PT_MIN : PT_MAX};
    end else if (sum[QB+2:CW-1] != {(QB+4-CW){sum[CW-1]}}) begin
      r = {1'b1, sum[QB+2] ? PT_MIN : PT_MAX};
    end else begin
      r = {1'b0, sum[CW-1:0]};
    end
    return r;
  endfunction

  assign resx = axis_out(sx119, qx119, ovx119, ngx119);
  assign resy = axis_out(sy119, qy119, ovy119, ngy119);

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit119;
      px_r   <= hit119 ? resx[CW-1:0] : '0;
      py_r   <= hit119 ? resy[CW-1:0] : '0;
      clip_r <= hit119 & (resx[CW] | resy[CW]);
    end
  end

  assign out_tdata = {py_r, px_r};
  assign out_tuser = {clip_r, hit_r};

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("miss with nonzero point");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (px_r == PT_MAX || px_r == PT_MIN || py_r == PT_MAX || py_r == PT_MIN))
    else $error("clip without saturated coordinate");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request lost at entry");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lci_pkg::*;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [CW-1:0]   sx;
    logic [CW-1:0]   sy;
    logic [CW-1:0]   ex;
    logic [CW-1:0]   ey;
    logic [CW-1:0]   cx;
    logic [CW-1:0]   cy;
    logic [RADW-1:0] rad;
  } query_t;

  typedef struct {
    logic          hit;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          clip;
  } crossing_t;

  localparam int CYCLE_LIMIT = 600000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;

  crossing_t pending_crossings[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        src_idle = 0;
  int        snk_idle = 0;
  int        hold_off = 0;

  always #1 clk = ~clk;

  line_circle_intersection_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic logic [191:0] isqrt(logic [191:0] x);
    logic [191:0] res;
    logic [191:0] bitv;
    res  = '0;
    bitv = 192'd1 << 190;
    for (int k = 0; k < 96; k++) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // {saturated, coordinate}: start + round(n*d/a), ties away from zero
  function automatic logic [CW:0] axis_coord(logic [CW-1:0] st, wide_t n, wide_t a, wide_t d);
    wide_t        p;
    logic [191:0] mag;
    logic [191:0] q;
    wide_t        v;
    logic         neg;
    p   = n * d;
    neg = p < 0;
    mag = neg ? -p : p;
    q   = ((mag << 1) + a) / (a << 1);
    if (q > (192'd1 << 34)) return {1'b1, neg ? PT_MIN : PT_MAX};
    v = $signed(st);
    v = neg ? v - $signed(q) : v + $signed(q);
    if (v > $signed(192'h7fff_ffff)) return {1'b1, PT_MAX};
    if (v < -$signed(192'h8000_0000)) return {1'b1, PT_MIN};
    return {1'b0, v[CW-1:0]};
  endfunction

  function automatic crossing_t nearer_crossing(query_t qy);
    crossing_t r;
    wide_t     dx, dy, rx, ry, rad, a, b, c, disc, n;
    logic [CW:0] ax, ay;
    dx  = wide_t'($signed(qy.ex)) - wide_t'($signed(qy.sx));
    dy  = wide_t'($signed(qy.ey)) - wide_t'($signed(qy.sy));
    rx  = wide_t'($signed(qy.sx)) - wide_t'($signed(qy.cx));
    ry  = wide_t'($signed(qy.sy)) - wide_t'($signed(qy.cy));
    rad = wide_t'({1'b0, qy.rad});
    a   = dx * dx + dy * dy;
    b   = rx * dx + ry * dy;
    c   = rx * rx + ry * ry - rad * rad;
    r   = '{hit: 1'b0, px: '0, py: '0, clip: 1'b0};
    if (a == 0) return r;
    disc = b * b - a * c;
    if (disc < 0) return r;
    n  = -b - $signed(isqrt(disc));
    ax = axis_coord(qy.sx, n, a, dx);
    ay = axis_coord(qy.sy, n, a, dy);
    r  = '{hit: 1'b1, px: ax[CW-1:0], py: ay[CW-1:0], clip: ax[CW] | ay[CW]};
    return r;
  endfunction

  task automatic report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("[%0d] %s: got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_query(query_t qy);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, qy.rad, qy.cy, qy.cx, qy.ey, qy.ex, qy.sy, qy.sx};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    pending_crossings.push_back(nearer_crossing(qy));
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rnd_small(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic logic [CW-1:0] rnd_edge();
    case ($urandom_range(5))
      0: return PT_MIN;
      1: return PT_MAX;
      2: return '0;
      3: return '1;
      4: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t qy;
    int     mode;
    int     span;
    mode = $urandom_range(9);
    span = 1 << $urandom_range(4, 24);
    qy.cx  = $urandom;
    qy.cy  = $urandom;
    qy.rad = RADW'($urandom_range(0, span));
    qy.sx  = qy.cx + rnd_small(span);
    qy.sy  = qy.cy + rnd_small(span);
    qy.ex  = qy.cx + rnd_small(span);
    qy.ey  = qy.cy + rnd_small(span);
    case (mode)
      0: begin
        qy.ex = qy.sx;
        qy.ey = qy.sy;
      end
      6, 7: begin
        qy = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
      end
      8: begin
        qy = '{rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge(), rnd_edge(),
               $urandom_range(1) ? 31'h7fff_ffff : 31'($urandom)};
      end
      9: begin
        qy.sy = qy.cy + {1'b0, qy.rad};
        qy.ey = qy.sy;
      end
      default: ;
    endcase
    return qy;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off   <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= snk_idle);
    end
  end

  always @(negedge clk) begin
    crossing_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_crossings.size() == 0) begin
        report("result with no request", out_tdata[31:0], '0);
      end else begin
        want = pending_crossings.pop_front();
        if (out_tuser[0] !== want.hit) report("hit", CW'(out_tuser[0]), CW'(want.hit));
        if (out_tuser[1] !== want.clip) report("clipped", CW'(out_tuser[1]), CW'(want.clip));
        if (out_tdata[31:0] !== want.px) report("point_x", out_tdata[31:0], want.px);
        if (out_tdata[63:32] !== want.py) report("point_y", out_tdata[63:32], want.py);
      end
    end
  end

  task automatic test_directed();
    send_query('{0, 0, 32'h0001_0000, 0, 32'h0000_8000, 0, 31'h0000_4000});
    send_query('{32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 31'h10_0000});
    send_query('{32'hfffb_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0, 0, 31'h5_0000});
    send_query('{0, 32'h0100_0000, 32'h0001_0000, 32'h0100_0000, 0, 0, 31'h1_0000});
    send_query('{0, 0, 32'hffff_ffff, 0, PT_MAX, 0, 31'h7fff_ffff});
    send_query('{0, 0, 32'd1, 0, PT_MAX, 0, 31'h7fff_ffff});
    send_query('{0, 0, 32'd1, 0, PT_MIN, 0, 31'h7fff_ffff});
    send_query('{0, 0, 0, 32'd1, 0, PT_MIN, 31'h7fff_ffff});
    send_query('{PT_MIN, PT_MIN, PT_MAX, PT_MAX, 0, 0, 31'h7fff_ffff});
    send_query('{PT_MAX, PT_MIN, PT_MIN, PT_MAX, PT_MAX, PT_MAX, 31'h7fff_ffff});
    send_query('{PT_MIN, PT_MAX, PT_MIN, PT_MAX, 0, 0, 31'h7fff_ffff});
    send_query('{'1, '1, 0, 0, '1, '1, 31'd0});
    send_query('{0, 0, 32'd1, 32'd1, 0, 0, 31'd0});
    send_query('{PT_MAX, PT_MAX, PT_MIN, PT_MIN, PT_MIN, PT_MAX, 31'h7fff_ffff});
    send_query('{32'd7, 32'd3, 32'd7, 32'd9, 0, 0, 31'd7});
    send_query('{PT_MIN, 0, PT_MIN, 32'd1, PT_MAX, 0, 31'h7fff_ffff});
    go_idle();
  endtask

  task automatic test_random(int count, int src_pct, int snk_pct);
    src_idle = src_pct;
    snk_idle = snk_pct;
    repeat (count) send_query(rnd_query());
    go_idle();
  endtask

  task automatic test_backpressure();
    src_idle = 0;
    snk_idle = 0;
    hold_off = 400;
    repeat (300) send_query(rnd_query());
    go_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450, 16, 88);
    test_random(450, 88, 16);
    test_random(450, 0, 0);
    test_backpressure();
    wait (pending_crossings.size() == 0);
    repeat (LAT + 80) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
